// ----- rtl/core/crmb_pkg.sv -----
`timescale 1ns / 1ps
package crmb_pkg;

	localparam int MAX_ITERATIONS = 30;
	localparam int ITER_W = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef logic signed [63:0] s64_t;
	typedef logic signed [47:0] s48_t;

	localparam s64_t S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam s64_t S64_MIN = 64'sh8000_0000_0000_0000;
	localparam s64_t MAX48 = 64'sh0000_7FFF_FFFF_FFFF;
	localparam s64_t MIN48 = 64'shFFFF_8000_0000_0000;
	localparam s64_t ONE_Q32 = 64'sh0000_0001_0000_0000;
	localparam s64_t TWO_EPS_Q40 = 64'sd65971;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NO_BRACKET = 2'd1;
	localparam logic [1:0] STAT_NO_CONV = 2'd2;

	localparam logic [2:0] REG_COEF_CONSTANT = 3'd0;
	localparam logic [2:0] REG_COEF_LINEAR = 3'd1;
	localparam logic [2:0] REG_COEF_SQUARE = 3'd2;
	localparam logic [2:0] REG_COEF_CUBE = 3'd3;
	localparam logic [2:0] REG_RANGE_WEIGHT = 3'd4;
	localparam logic [2:0] REG_TOLERANCE = 3'd5;
	localparam logic [2:0] REG_SEARCH_LOW = 3'd6;
	localparam logic [2:0] REG_SEARCH_HIGH = 3'd7;

	localparam logic [5:0] SH_CUBE = 6'd19;
	localparam logic [5:0] SH_SQUARE = 6'd36;
	localparam logic [5:0] SH_LINEAR = 6'd40;
	localparam logic [5:0] SH_EPS = 6'd40;
	localparam logic [5:0] SH_Q32 = 6'd32;
	localparam logic [5:0] SH_WEIGHT = 6'd16;

	typedef struct packed {
		s64_t coef_constant;
		s64_t coef_linear;
		s64_t coef_square;
		s64_t coef_cube;
		logic [31:0] range_weight;
		logic [31:0] tolerance;
		s48_t search_low;
		s48_t search_high;
	} cfg_t;

	typedef struct packed {
		logic inverse;
		s48_t distance;
		s64_t scaled;
	} item_t;

	typedef struct packed {
		logic start;
		logic [5:0] shift;
		s64_t x;
		s64_t y;
	} op_req_t;

	typedef struct packed {
		logic done;
		s64_t value;
	} op_rsp_t;

	function automatic logic [63:0] mag64(input s64_t x);
		logic [63:0] u;
		u = x;
		return x[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic s64_t sadd64(input s64_t a, input s64_t b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic s64_t ssub64(input s64_t a, input s64_t b);
		logic signed [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic s64_t sabs64(input s64_t x);
		return x[63] ? ssub64(64'sd0, x) : x;
	endfunction

	function automatic s48_t clamp48(input s64_t x);
		if (x > MAX48) return MAX48[47:0];
		if (x < MIN48) return MIN48[47:0];
		return x[47:0];
	endfunction

	function automatic s64_t sx48(input s48_t v);
		return {{16{v[47]}}, v};
	endfunction

	function automatic logic same_sign(input s64_t a, input s64_t b);
		return (a > 64'sd0 && b > 64'sd0) || (a < 64'sd0 && b < 64'sd0);
	endfunction

endpackage

// ----- rtl/core/crmb_front.sv -----
`timescale 1ns / 1ps
module crmb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_valid,
	output logic                s_ready,
	input  logic                s_kind,
	input  crmb_pkg::s48_t      s_dist,
	output logic                push,
	input  logic                push_ready,
	output crmb_pkg::item_t     push_data
);

	logic            valid_q;
	crmb_pkg::item_t item_q;
	crmb_pkg::s64_t  x64;
	crmb_pkg::s64_t  x1000;

	// x * 1000 = x*1024 - x*16 - x*8
	assign x64 = crmb_pkg::sx48(s_dist);
	assign x1000 = (x64 <<< 10) - (x64 <<< 4) - (x64 <<< 3);

	assign s_ready = !valid_q || push_ready;
	assign push = valid_q;
	assign push_data = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (s_valid && s_ready) begin
				valid_q <= 1'b1;
			end else if (push_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			item_q.inverse <= s_kind;
			item_q.distance <= s_dist;
			item_q.scaled <= x1000;
		end
	end

endmodule

// ----- rtl/core/crmb_fifo.sv -----
`timescale 1ns / 1ps
module crmb_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             push_ready,
	input  crmb_pkg::item_t  push_data,
	output logic             pop_valid,
	input  logic             pop,
	output crmb_pkg::item_t  pop_data
);

	crmb_pkg::item_t                mem_q [crmb_pkg::QUEUE_DEPTH];
	logic [crmb_pkg::QPTR_W-1:0]    wptr_q;
	logic [crmb_pkg::QPTR_W-1:0]    rptr_q;
	logic [crmb_pkg::QPTR_W:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	assign push_ready = count_q != (crmb_pkg::QPTR_W + 1)'(crmb_pkg::QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_data;
	end

endmodule

// ----- rtl/core/crmb_mul.sv -----
`timescale 1ns / 1ps
module crmb_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  crmb_pkg::op_req_t req,
	output crmb_pkg::op_rsp_t rsp
);

	logic           busy_q;
	logic           done_q;
	logic [2:0]     phase_q;
	logic [63:0]    ma_q;
	logic [63:0]    mb_q;
	logic           neg_q;
	logic [5:0]     sh_q;
	logic [127:0]   acc_q;
	crmb_pkg::s64_t res_q;
	logic [31:0]    xa;
	logic [31:0]    yb;
	logic [63:0]    pp;
	logic [127:0]   pp_sh;
	logic [127:0]   rnd;
	logic [127:0]   shifted;
	crmb_pkg::s64_t sat;

	// one 32x32 partial product per phase, then round, then shift
	assign xa = phase_q[1] ? ma_q[63:32] : ma_q[31:0];
	assign yb = phase_q[0] ? mb_q[63:32] : mb_q[31:0];
	assign pp = xa * yb;
	assign rnd = 128'd1 << (sh_q - 6'd1);
	assign shifted = acc_q >> sh_q;

	always_comb begin
		case ({phase_q[1], phase_q[0]})
			2'b00: pp_sh = {64'd0, pp};
			2'b11: pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		if (|shifted[127:63]) begin
			sat = neg_q ? crmb_pkg::S64_MIN : crmb_pkg::S64_MAX;
		end else begin
			sat = neg_q ? -shifted[63:0] : shifted[63:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.value = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				phase_q <= '0;
			end else if (busy_q) begin
				phase_q <= phase_q + 3'd1;
				if (phase_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q <= crmb_pkg::mag64(req.x);
			mb_q <= crmb_pkg::mag64(req.y);
			neg_q <= req.x[63] ^ req.y[63];
			sh_q <= req.shift;
			acc_q <= '0;
		end else if (busy_q) begin
			case (phase_q)
				3'd0, 3'd1, 3'd2, 3'd3: acc_q <= acc_q + pp_sh;
				3'd4: acc_q <= acc_q + rnd;
				3'd5: res_q <= sat;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/crmb_div.sv -----
`timescale 1ns / 1ps
module crmb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  crmb_pkg::op_req_t req,
	output crmb_pkg::op_rsp_t rsp
);

	localparam logic [2:0] P_IDLE = 3'd0;
	localparam logic [2:0] P_PREP = 3'd1;
	localparam logic [2:0] P_CHK  = 3'd2;
	localparam logic [2:0] P_RUN  = 3'd3;
	localparam logic [2:0] P_FIN  = 3'd4;

	logic [2:0]     phase_q;
	logic           done_q;
	logic [5:0]     cnt_q;
	logic [63:0]    mn_q;
	logic [63:0]    md_q;
	logic           neg_q;
	logic           nneg_q;
	logic           nzero_q;
	logic [5:0]     sh_q;
	logic [63:0]    rem_q;
	logic [63:0]    lo_q;
	logic [63:0]    quo_q;
	crmb_pkg::s64_t res_q;
	logic [127:0]   num;
	logic [64:0]    rem2;
	logic           take;
	crmb_pkg::s64_t sat_sign;

	assign num = ({64'd0, mn_q} << sh_q) + {65'd0, md_q[63:1]};
	assign rem2 = {rem_q, lo_q[63]};
	assign take = rem2 >= {1'b0, md_q};
	assign sat_sign = neg_q ? crmb_pkg::S64_MIN : crmb_pkg::S64_MAX;

	assign rsp.done = done_q;
	assign rsp.value = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				phase_q <= P_PREP;
			end else begin
				case (phase_q)
					P_PREP: begin
						if (md_q == '0) begin
							phase_q <= P_IDLE;
							done_q <= 1'b1;
						end else begin
							phase_q <= P_CHK;
						end
					end
					P_CHK: begin
						if (rem_q >= md_q) begin
							phase_q <= P_IDLE;
							done_q <= 1'b1;
						end else begin
							phase_q <= P_RUN;
						end
					end
					P_RUN: if (cnt_q == 6'd63) phase_q <= P_FIN;
					P_FIN: begin
						phase_q <= P_IDLE;
						done_q <= 1'b1;
					end
					default: phase_q <= P_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mn_q <= crmb_pkg::mag64(req.x);
			md_q <= crmb_pkg::mag64(req.y);
			neg_q <= req.x[63] ^ req.y[63];
			nneg_q <= req.x[63];
			nzero_q <= req.x == 64'sd0;
			sh_q <= req.shift;
		end else begin
			case (phase_q)
				P_PREP: begin
					{rem_q, lo_q} <= num;
					if (md_q == '0) begin
						res_q <= nzero_q ? 64'sd0
							: (nneg_q ? crmb_pkg::S64_MIN : crmb_pkg::S64_MAX);
					end
				end
				P_CHK: begin
					cnt_q <= '0;
					quo_q <= '0;
					if (rem_q >= md_q) res_q <= sat_sign;
				end
				P_RUN: begin
					cnt_q <= cnt_q + 6'd1;
					lo_q <= {lo_q[62:0], 1'b0};
					quo_q <= {quo_q[62:0], take};
					rem_q <= take ? 64'(rem2 - {1'b0, md_q}) : rem2[63:0];
				end
				P_FIN: res_q <= quo_q[63] ? sat_sign : (neg_q ? -quo_q : quo_q);
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/core/crmb_back.sv -----
`timescale 1ns / 1ps
module crmb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  crmb_pkg::cfg_t     cfg,
	input  logic               item_valid,
	input  crmb_pkg::item_t    item,
	output logic               item_pop,
	output logic               m_valid,
	input  logic               m_ready,
	output crmb_pkg::s48_t     m_dist,
	output logic [1:0]         m_status
);

	localparam logic [5:0] ST_IDLE    = 6'd0;
	localparam logic [5:0] ST_WAIT    = 6'd1;
	localparam logic [5:0] ST_FWD_DIV = 6'd2;
	localparam logic [5:0] ST_FWD_END = 6'd3;
	localparam logic [5:0] ST_INV_SC  = 6'd4;
	localparam logic [5:0] ST_FA      = 6'd5;
	localparam logic [5:0] ST_FB      = 6'd6;
	localparam logic [5:0] ST_L0      = 6'd7;
	localparam logic [5:0] ST_L1      = 6'd8;
	localparam logic [5:0] ST_L2      = 6'd9;
	localparam logic [5:0] ST_L3      = 6'd10;
	localparam logic [5:0] ST_L4      = 6'd11;
	localparam logic [5:0] ST_L5      = 6'd12;
	localparam logic [5:0] ST_L6      = 6'd13;
	localparam logic [5:0] ST_L7      = 6'd14;
	localparam logic [5:0] ST_L8      = 6'd15;
	localparam logic [5:0] ST_L9      = 6'd16;
	localparam logic [5:0] ST_L10     = 6'd17;
	localparam logic [5:0] ST_L11     = 6'd18;
	localparam logic [5:0] ST_L12     = 6'd19;
	localparam logic [5:0] ST_L13     = 6'd20;
	localparam logic [5:0] ST_L14     = 6'd21;
	localparam logic [5:0] ST_PQ      = 6'd22;
	localparam logic [5:0] ST_PQ1     = 6'd23;
	localparam logic [5:0] ST_T1      = 6'd24;
	localparam logic [5:0] ST_T2      = 6'd25;
	localparam logic [5:0] ST_T3      = 6'd26;
	localparam logic [5:0] ST_T4      = 6'd27;
	localparam logic [5:0] ST_STEP    = 6'd28;
	localparam logic [5:0] ST_FBN     = 6'd29;
	localparam logic [5:0] ST_C0      = 6'd30;
	localparam logic [5:0] ST_C1      = 6'd31;
	localparam logic [5:0] ST_C2      = 6'd32;
	localparam logic [5:0] ST_OUT     = 6'd33;

	logic [5:0]                   state_q;
	logic [5:0]                   ret_q;
	logic [5:0]                   cret_q;
	logic [crmb_pkg::ITER_W-1:0]  iter_q;
	crmb_pkg::op_req_t            op_q;
	logic                         op_div_q;
	crmb_pkg::op_req_t            mul_req;
	crmb_pkg::op_req_t            div_req;
	crmb_pkg::op_rsp_t            mul_rsp;
	crmb_pkg::op_rsp_t            div_rsp;

	crmb_pkg::s48_t slant_q, cx_q, a_q, b_q, c_q, xm_q, rd_q;
	crmb_pkg::s64_t d_q, e_q, fa_q, fb_q, fc_q, tol1_q, s_q, qa_q, rm1_q, qmr_q;
	crmb_pkg::s64_t tmp_q, p_q, q_q, t_q;
	logic [1:0]     rs_q;
	logic           out_valid_q;
	crmb_pkg::s48_t out_dist_q;
	logic [1:0]     out_stat_q;

	crmb_pkg::s64_t mul_res, div_res, cub, fnew, weight, half_tol;
	crmb_pkg::s64_t a64, b64, c64, xm64, xm2, xm3, diff, dsum, eq, tmin, step_b;
	logic [31:0]    half_tol32;

	crmb_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	crmb_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	always_comb begin
		mul_req = op_q;
		mul_req.start = op_q.start && !op_div_q;
		div_req = op_q;
		div_req.start = op_q.start && op_div_q;
	end

	assign mul_res = mul_rsp.value;
	assign div_res = div_rsp.value;
	assign cub = crmb_pkg::sadd64(cfg.coef_constant, mul_res);
	assign fnew = crmb_pkg::ssub64(crmb_pkg::sx48(slant_q), cub);
	assign weight = {32'd0, (cfg.range_weight == '0) ? 32'd1 : cfg.range_weight};
	assign half_tol32 = 32'(({1'b0, cfg.tolerance} + 33'd1) >> 1);
	assign half_tol = {32'd0, half_tol32};
	assign a64 = crmb_pkg::sx48(a_q);
	assign b64 = crmb_pkg::sx48(b_q);
	assign c64 = crmb_pkg::sx48(c_q);
	assign xm64 = crmb_pkg::sx48(xm_q);
	assign xm2 = xm64 + xm64;
	assign xm3 = xm2 + xm64;
	assign diff = c64 - b64;
	// halve toward zero
	assign dsum = diff + {63'd0, diff[63]};
	assign eq = crmb_pkg::sabs64(mul_res);
	assign tmin = (t_q > eq) ? eq : t_q;

	always_comb begin
		if (crmb_pkg::mag64(d_q) > tol1_q) begin
			step_b = crmb_pkg::sadd64(b64, d_q);
		end else if (!xm_q[47]) begin
			step_b = crmb_pkg::sadd64(b64, tol1_q);
		end else begin
			step_b = crmb_pkg::ssub64(b64, tol1_q);
		end
	end

	assign item_pop = (state_q == ST_IDLE) && item_valid;
	assign m_valid = out_valid_q;
	assign m_dist = out_dist_q;
	assign m_status = out_stat_q;

	task automatic launch(input logic use_div, input crmb_pkg::s64_t x,
		input crmb_pkg::s64_t y, input logic [5:0] sh, input logic [5:0] ret);
		op_div_q <= use_div;
		op_q.start <= 1'b1;
		op_q.x <= x;
		op_q.y <= y;
		op_q.shift <= sh;
		ret_q <= ret;
		state_q <= ST_WAIT;
	endtask

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q.start <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			op_q.start <= 1'b0;
			if (m_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (!item.inverse) begin
							cx_q <= item.distance;
							cret_q <= ST_FWD_DIV;
							state_q <= ST_C0;
						end else begin
							launch(1'b0, item.scaled, weight, crmb_pkg::SH_WEIGHT, ST_INV_SC);
						end
					end
				end
				ST_WAIT: if (mul_rsp.done || div_rsp.done) state_q <= ret_q;
				ST_C0: launch(1'b0, crmb_pkg::sx48(cx_q), cfg.coef_cube,
					crmb_pkg::SH_CUBE, ST_C1);
				ST_C1: launch(1'b0, crmb_pkg::sx48(cx_q),
					crmb_pkg::sadd64(cfg.coef_square, mul_res), crmb_pkg::SH_SQUARE, ST_C2);
				ST_C2: launch(1'b0, crmb_pkg::sx48(cx_q),
					crmb_pkg::sadd64(cfg.coef_linear, mul_res), crmb_pkg::SH_LINEAR, cret_q);
				ST_FWD_DIV: launch(1'b1, crmb_pkg::sx48(crmb_pkg::clamp48(cub)), weight,
					crmb_pkg::SH_WEIGHT, ST_FWD_END);
				ST_FWD_END: begin
					rd_q <= crmb_pkg::clamp48(div_res);
					rs_q <= crmb_pkg::STAT_OK;
					state_q <= ST_OUT;
				end
				ST_INV_SC: begin
					slant_q <= crmb_pkg::clamp48(mul_res);
					cx_q <= cfg.search_low;
					cret_q <= ST_FA;
					state_q <= ST_C0;
				end
				ST_FA: begin
					fa_q <= fnew;
					cx_q <= cfg.search_high;
					cret_q <= ST_FB;
					state_q <= ST_C0;
				end
				ST_FB: begin
					if (fa_q == fnew || crmb_pkg::same_sign(fa_q, fnew)) begin
						rd_q <= '0;
						rs_q <= crmb_pkg::STAT_NO_BRACKET;
						state_q <= ST_OUT;
					end else begin
						fb_q <= fnew;
						fc_q <= fnew;
						a_q <= cfg.search_low;
						b_q <= cfg.search_high;
						c_q <= '0;
						d_q <= '0;
						e_q <= '0;
						iter_q <= '0;
						state_q <= ST_L0;
					end
				end
				ST_L0: begin
					if (crmb_pkg::same_sign(fb_q, fc_q)) begin
						c_q <= a_q;
						fc_q <= fa_q;
						d_q <= crmb_pkg::ssub64(b64, a64);
						e_q <= crmb_pkg::ssub64(b64, a64);
					end
					state_q <= ST_L1;
				end
				ST_L1: begin
					// keep b as the best estimate
					if (crmb_pkg::mag64(fc_q) < crmb_pkg::mag64(fb_q)) begin
						a_q <= b_q;
						b_q <= c_q;
						c_q <= b_q;
						fa_q <= fb_q;
						fb_q <= fc_q;
						fc_q <= fb_q;
					end
					state_q <= ST_L2;
				end
				ST_L2: launch(1'b0, crmb_pkg::sabs64(b64), crmb_pkg::TWO_EPS_Q40,
					crmb_pkg::SH_EPS, ST_L3);
				ST_L3: begin
					tol1_q <= crmb_pkg::sadd64(mul_res, half_tol);
					xm_q <= dsum[48:1];
					state_q <= ST_L4;
				end
				ST_L4: begin
					if (crmb_pkg::mag64(xm64) <= tol1_q || fb_q == 64'sd0) begin
						rd_q <= b_q;
						rs_q <= crmb_pkg::STAT_OK;
						state_q <= ST_OUT;
					end else if (crmb_pkg::mag64(e_q) >= tol1_q &&
						crmb_pkg::mag64(fa_q) > crmb_pkg::mag64(fb_q)) begin
						launch(1'b1, fb_q, fa_q, crmb_pkg::SH_Q32, ST_L5);
					end else begin
						d_q <= xm64;
						e_q <= xm64;
						state_q <= ST_STEP;
					end
				end
				ST_L5: begin
					s_q <= div_res;
					if (a_q == c_q) begin
						launch(1'b0, xm2, div_res, crmb_pkg::SH_Q32, ST_L6);
					end else begin
						launch(1'b1, fa_q, fc_q, crmb_pkg::SH_Q32, ST_L7);
					end
				end
				ST_L6: begin
					p_q <= mul_res;
					q_q <= crmb_pkg::ssub64(crmb_pkg::ONE_Q32, s_q);
					state_q <= ST_PQ;
				end
				ST_L7: begin
					qa_q <= div_res;
					launch(1'b1, fb_q, fc_q, crmb_pkg::SH_Q32, ST_L8);
				end
				ST_L8: begin
					rm1_q <= crmb_pkg::ssub64(div_res, crmb_pkg::ONE_Q32);
					qmr_q <= crmb_pkg::ssub64(qa_q, div_res);
					launch(1'b0, xm2, qa_q, crmb_pkg::SH_Q32, ST_L9);
				end
				ST_L9: launch(1'b0, mul_res, qmr_q, crmb_pkg::SH_Q32, ST_L10);
				ST_L10: begin
					tmp_q <= mul_res;
					launch(1'b0, crmb_pkg::ssub64(b64, a64), rm1_q, crmb_pkg::SH_Q32, ST_L11);
				end
				ST_L11: launch(1'b0, s_q, crmb_pkg::ssub64(tmp_q, mul_res),
					crmb_pkg::SH_Q32, ST_L12);
				ST_L12: begin
					p_q <= mul_res;
					launch(1'b0, crmb_pkg::ssub64(qa_q, crmb_pkg::ONE_Q32), rm1_q,
						crmb_pkg::SH_Q32, ST_L13);
				end
				ST_L13: launch(1'b0, mul_res, crmb_pkg::ssub64(s_q, crmb_pkg::ONE_Q32),
					crmb_pkg::SH_Q32, ST_L14);
				ST_L14: begin
					q_q <= mul_res;
					state_q <= ST_PQ;
				end
				ST_PQ: begin
					if (p_q > 64'sd0) q_q <= crmb_pkg::ssub64(64'sd0, q_q);
					p_q <= crmb_pkg::sabs64(p_q);
					state_q <= ST_PQ1;
				end
				ST_PQ1: launch(1'b0, xm3, q_q, crmb_pkg::SH_Q32, ST_T1);
				ST_T1: begin
					tmp_q <= mul_res;
					launch(1'b0, tol1_q, q_q, crmb_pkg::SH_Q32, ST_T2);
				end
				ST_T2: begin
					t_q <= crmb_pkg::ssub64(tmp_q, crmb_pkg::sabs64(mul_res));
					launch(1'b0, e_q, q_q, crmb_pkg::SH_Q32, ST_T3);
				end
				ST_T3: begin
					// accept the interpolated step, else fall back to bisection
					if (crmb_pkg::sadd64(p_q, p_q) < tmin) begin
						e_q <= d_q;
						launch(1'b1, p_q, q_q, crmb_pkg::SH_Q32, ST_T4);
					end else begin
						d_q <= xm64;
						e_q <= xm64;
						state_q <= ST_STEP;
					end
				end
				ST_T4: begin
					d_q <= div_res;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					a_q <= b_q;
					fa_q <= fb_q;
					b_q <= crmb_pkg::clamp48(step_b);
					cx_q <= crmb_pkg::clamp48(step_b);
					cret_q <= ST_FBN;
					state_q <= ST_C0;
				end
				ST_FBN: begin
					fb_q <= fnew;
					if (iter_q == crmb_pkg::ITER_W'(crmb_pkg::MAX_ITERATIONS)) begin
						rd_q <= '0;
						rs_q <= crmb_pkg::STAT_NO_CONV;
						state_q <= ST_OUT;
					end else begin
						iter_q <= iter_q + 1'b1;
						state_q <= ST_L0;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || m_ready)) begin
			out_dist_q <= rd_q;
			out_stat_q <= rs_q;
		end
	end

endmodule

// ----- rtl/core/cubic_range_map_brent_solver_core.sv -----
`timescale 1ns / 1ps
// channel   | direction | handshake                      | payload
// s_axis    | in        | s_axis_tvalid / s_axis_tready  | tuser kind, tdata distance_in
// m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata distance_out, status
// cfg       | in        | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// Forward items take three Horner products on the multiplier (four partial products,
// round, saturate) and one serial division of up to 64 steps. Inverse items take a setup
// stage plus up to 31 solver iterations, each using the serial divider
// (up to four divisions an iteration) and the shared multiplier.
// Reset clears the queue, the sequencer and the output valid flag; config registers take defaults.
// Two queued items and one held result let input and output stall independently.
module cubic_range_map_brent_solver_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // [47:0] distance_in
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [47:0] distance_out, [49:48] status, rest zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	crmb_pkg::cfg_t  cfg_q;
	logic            push;
	logic            push_ready;
	crmb_pkg::item_t push_data;
	logic            pop_valid;
	logic            pop;
	crmb_pkg::item_t pop_data;
	crmb_pkg::s48_t  out_dist;
	logic [1:0]      out_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coef_constant <= '0;
			cfg_q.coef_linear <= '0;
			cfg_q.coef_square <= '0;
			cfg_q.coef_cube <= '0;
			cfg_q.range_weight <= 32'd65536;
			cfg_q.tolerance <= 32'd6554;
			cfg_q.search_low <= '0;
			cfg_q.search_high <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				crmb_pkg::REG_COEF_CONSTANT: cfg_q.coef_constant <= cfg_data;
				crmb_pkg::REG_COEF_LINEAR: cfg_q.coef_linear <= cfg_data;
				crmb_pkg::REG_COEF_SQUARE: cfg_q.coef_square <= cfg_data;
				crmb_pkg::REG_COEF_CUBE: cfg_q.coef_cube <= cfg_data;
				crmb_pkg::REG_RANGE_WEIGHT: cfg_q.range_weight <= cfg_data[31:0];
				crmb_pkg::REG_TOLERANCE: cfg_q.tolerance <= cfg_data[31:0];
				crmb_pkg::REG_SEARCH_LOW: cfg_q.search_low <= cfg_data[47:0];
				crmb_pkg::REG_SEARCH_HIGH: cfg_q.search_high <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	crmb_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
		.s_kind(s_axis_tuser), .s_dist(s_axis_tdata),
		.push(push), .push_ready(push_ready), .push_data(push_data)
	);

	crmb_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_ready(push_ready), .push_data(push_data),
		.pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
	);

	crmb_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.item_valid(pop_valid), .item(pop_data), .item_pop(pop),
		.m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
		.m_dist(out_dist), .m_status(out_stat)
	);

	assign m_axis_tdata = {6'd0, out_stat, out_dist};

endmodule

// ----- rtl/core/crmb_checker.sv -----
`timescale 1ns / 1ps
module crmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[49:48] == crmb_pkg::STAT_OK ||
			m_axis_tdata[49:48] == crmb_pkg::STAT_NO_BRACKET ||
			m_axis_tdata[49:48] == crmb_pkg::STAT_NO_CONV))
		else $error("undefined status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[49:48] != crmb_pkg::STAT_OK
			|-> m_axis_tdata[47:0] == 48'd0)
		else $error("failed solve with nonzero distance");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[55:50] == 6'd0)
		else $error("padding bits set");

endmodule

bind cubic_range_map_brent_solver_core crmb_checker u_crmb_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
